/* hdl/tcr_pkg.sv */
// ----------------------------------------------------------------------------
// tcr_pkg: shared constants for the triangle coverage rasterizer
// Widths of coordinates, fixed-point edge values and command codes.
// ----------------------------------------------------------------------------
package tcr_pkg;

   localparam int PLACES    = 16384;
   localparam int FRAC_BITS = 16;

   localparam int ADDR_W  = $clog2(PLACES);
   localparam int COORD_W = 13;                   // corner row/column
   localparam int DIFF_W  = COORD_W + 1;          // difference of two corners
   localparam int DEN_W   = COORD_W;              // row span divisor, 1..8191
   localparam int NUM_W   = COORD_W + FRAC_BITS;  // |diff| << FRAC_BITS
   localparam int INC_W   = NUM_W + 1;            // signed edge step
   localparam int POS_W   = COORD_W + FRAC_BITS + 3;
   localparam int COL_W   = POS_W - FRAC_BITS;    // truncated edge column
   localparam int BASE_W  = 17;                   // row*row_length + col
   localparam int ROW_W   = COORD_W + 1;
   localparam int CNT_W   = COORD_W + 2;
   localparam int SKIP_W  = COORD_W;
   localparam int CFG_W   = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_MARK  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_ROW   = 2'd1;

endpackage

/* hdl/tcr_div.sv */
// ----------------------------------------------------------------------------
// tcr_div: edge step divider
// Signed (num << FRAC_BITS) / den, truncated toward zero, one bit a cycle.
// ----------------------------------------------------------------------------
module tcr_div import tcr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DIFF_W-1:0] num,
   input  logic        [DEN_W-1:0]  den,
   output logic                     done,
   output logic signed [INC_W-1:0]  quot
);

   localparam int CNT_BITS = $clog2(NUM_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]    n_ff, n_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]      trial;
   logic [DIFF_W-1:0]   mag;

   always_comb begin
      mag = num[DIFF_W-1] ? DIFF_W'(-num) : num;
      trial = {rem_ff, n_ff[NUM_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in = neg_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      n_in = n_ff;
      cnt_in = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in = num[DIFF_W-1];
         den_in = den;
         rem_in = '0;
         n_in = {mag[DEN_W-1:0], {FRAC_BITS{1'b0}}};
         cnt_in = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            n_in = {n_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            n_in = {n_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      n_ff <= n_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed({1'b0, n_ff}) : $signed({1'b0, n_ff});

endmodule

/* hdl/tcr_map.sv */
// ----------------------------------------------------------------------------
// tcr_map: coverage bit store
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tcr_map import tcr_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic              rd_data
);

   logic mem [PLACES];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/triangle_coverage_rasterizer.sv */
// ----------------------------------------------------------------------------
// triangle_coverage_rasterizer: scanline triangle fill into a coverage map
// Clear, mark-triangle and read-place commands on a 1-bit row-major map.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  req     | in        | req_valid/req_ready  | cmd, rows/cols a..c, index
//  rsp     | out       | rsp_valid/rsp_ready  | place_value
//  csr     | in        | csr_we (no wait)     | csr_index, csr_wdata
//
//  Clear writes one place per cycle.
//  Mark: 3 divisions, a setup, then a walk over the rows; rows that write
//  fill their span, and a row whose span runs past the map capacity is
//  dropped; the single map write port sets the per-row cost. Walking stops
//  at the first row past last_row.
//  Reset: a clearing pass over all PLACES runs first; req_ready stays low.
//  Stalls: one transfer is in work at a time; a finished result waits in the
//  output register and the next request is taken while it waits.
// ----------------------------------------------------------------------------
module triangle_coverage_rasterizer import tcr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_cmd,
   input  logic signed [COORD_W-1:0] req_row_a,
   input  logic signed [COORD_W-1:0] req_row_b,
   input  logic signed [COORD_W-1:0] req_row_c,
   input  logic signed [COORD_W-1:0] req_col_a,
   input  logic signed [COORD_W-1:0] req_col_b,
   input  logic signed [COORD_W-1:0] req_col_c,
   input  logic [ADDR_W-1:0]         req_read_index,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_place_value,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CFG_W-1:0]          csr_wdata
);

   // sequencer states
   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_CLEAR  = 5'd1;
   localparam logic [4:0] ST_READ   = 5'd2;
   localparam logic [4:0] ST_RWAIT  = 5'd3;
   localparam logic [4:0] ST_RESP   = 5'd4;
   localparam logic [4:0] ST_DIV_GO = 5'd5;
   localparam logic [4:0] ST_DIV_WT = 5'd6;
   localparam logic [4:0] ST_PREP   = 5'd7;
   localparam logic [4:0] ST_MULL   = 5'd8;
   localparam logic [4:0] ST_MULR   = 5'd9;
   localparam logic [4:0] ST_ADDR   = 5'd10;
   localparam logic [4:0] ST_HALF2  = 5'd11;
   localparam logic [4:0] ST_HALF2B = 5'd12;
   localparam logic [4:0] ST_SPAN   = 5'd13;
   localparam logic [4:0] ST_BASE   = 5'd14;
   localparam logic [4:0] ST_FILL   = 5'd15;
   localparam logic [4:0] ST_NEXT   = 5'd16;

   localparam int PROD_W = INC_W + SKIP_W + 1;
   localparam logic [BASE_W-1:0] PLACES_B = BASE_W'(PLACES);
   localparam logic [POS_W-1:0] FRAC_MASK = POS_W'((1 << FRAC_BITS) - 1);

   // truncate a fixed-point edge position toward zero
   function automatic logic signed [COL_W-1:0] trunc_col(input logic signed [POS_W-1:0] p);
      logic [POS_W-1:0] t;
      t = p + (p[POS_W-1] ? FRAC_MASK : '0);
      return t[POS_W-1:FRAC_BITS];
   endfunction

   // corner column at the binary point
   function automatic logic signed [POS_W-1:0] col_pos(input logic signed [COORD_W-1:0] c);
      return {{(POS_W-COORD_W-FRAC_BITS){c[COORD_W-1]}}, c, {FRAC_BITS{1'b0}}};
   endfunction

   logic [4:0] state_ff, state_in;

   // configuration
   logic [CFG_W-1:0] row_len_ff, row_len_in;
   logic [CFG_W-1:0] last_row_ff, last_row_in;

   // captured request
   logic [1:0]                cmd_ff;
   logic signed [COORD_W-1:0] ra_ff, rb_ff, rc_ff, ca_ff, cb_ff, cc_ff;
   logic [ADDR_W-1:0]         idx_ff;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_val_ff, rsp_val_in;
   logic val_ff, val_in;
   logic clr_resp_ff, clr_resp_in;

   // walk datapath
   logic signed [INC_W-1:0] tm_inc_ff, tm_inc_in, tb_inc_ff, tb_inc_in, mb_inc_ff, mb_inc_in;
   logic signed [INC_W-1:0] linc_ff, linc_in, rinc_ff, rinc_in;
   logic signed [POS_W-1:0] lpos_ff, lpos_in, rpos_ff, rpos_in;
   logic signed [POS_W-1:0] prod_ff, prod_in;
   logic signed [ROW_W-1:0] row_ff, row_in;
   logic signed [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SKIP_W-1:0]       skip_ff, skip_in;
   logic                    half_ff, half_in;
   logic                    mb_right_ff, mb_right_in;
   logic [1:0]              div_sel_ff, div_sel_in;
   logic [CFG_W-1:0]        lo_ff, lo_in, hi_ff, hi_in;
   logic [BASE_W-1:0]       addr_ff, addr_in, end_ff, end_in;

   // sorted corners
   logic signed [COORD_W-1:0] rt, rm, rbo, ct, cm, cbo;

   // shared units
   logic                     div_start, div_done;
   logic signed [DIFF_W-1:0] div_num, span;
   logic [DEN_W-1:0]         div_den;
   logic signed [INC_W-1:0]  div_quot;
   logic signed [INC_W-1:0]  mul_a;
   logic [SKIP_W-1:0]        mul_b;
   logic signed [PROD_W-1:0] mul_p;

   logic              map_we, map_wd, map_rd;
   logic [ADDR_W-1:0] map_wa;

   logic signed [COL_W-1:0] lo_t, hi_t, lo_c, hi_c, rl_s;
   logic [2*CFG_W-1:0]      base;
   logic [BASE_W-1:0]       at_v, end_v;
   logic signed [ROW_W-1:0] rt_ext;

   // sort corners by row, ties as the model breaks them
   always_comb begin
      if (rb_ff > ra_ff) begin
         if (rc_ff > rb_ff) begin
            rt = ra_ff; rm = rb_ff; rbo = rc_ff; ct = ca_ff; cm = cb_ff; cbo = cc_ff;
         end else if (rc_ff > ra_ff) begin
            rt = ra_ff; rm = rc_ff; rbo = rb_ff; ct = ca_ff; cm = cc_ff; cbo = cb_ff;
         end else begin
            rt = rc_ff; rm = ra_ff; rbo = rb_ff; ct = cc_ff; cm = ca_ff; cbo = cb_ff;
         end
      end else if (rc_ff > ra_ff) begin
         rt = rb_ff; rm = ra_ff; rbo = rc_ff; ct = cb_ff; cm = ca_ff; cbo = cc_ff;
      end else if (rc_ff > rb_ff) begin
         rt = rb_ff; rm = rc_ff; rbo = ra_ff; ct = cb_ff; cm = cc_ff; cbo = ca_ff;
      end else begin
         rt = rc_ff; rm = rb_ff; rbo = ra_ff; ct = cc_ff; cm = cb_ff; cbo = ca_ff;
      end
   end

   // divider operands: top-mid, top-bottom, mid-bottom edges
   always_comb begin
      unique case (div_sel_ff)
         2'd0: begin
            div_num = DIFF_W'(cm) - DIFF_W'(ct);
            span = DIFF_W'(rm) - DIFF_W'(rt);
         end
         2'd1: begin
            div_num = DIFF_W'(cbo) - DIFF_W'(ct);
            span = DIFF_W'(rbo) - DIFF_W'(rt);
         end
         default: begin
            div_num = DIFF_W'(cbo) - DIFF_W'(cm);
            span = DIFF_W'(rbo) - DIFF_W'(rm);
         end
      endcase
      // flat half divides by one
      div_den = (span < 1) ? DEN_W'(1) : span[DEN_W-1:0];
   end

   assign div_start = (state_ff == ST_DIV_GO);

   tcr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // shared step multiplier: inc * skip
   always_comb begin
      case (state_ff)
         ST_MULL: mul_a = linc_ff;
         ST_MULR: mul_a = rinc_ff;
         default: mul_a = mb_inc_ff;
      endcase
      mul_b = skip_ff;
      mul_p = mul_a * $signed({1'b0, mul_b});
   end

   // span bounds for the current row
   always_comb begin
      lo_t = trunc_col(lpos_ff);
      hi_t = trunc_col(rpos_ff);
      rl_s = $signed({{(COL_W-CFG_W){1'b0}}, row_len_ff});
      lo_c = lo_t[COL_W-1] ? '0 : lo_t;
      hi_c = (hi_t > rl_s) ? rl_s : hi_t;
      base = row_ff[CFG_W-1:0] * row_len_ff;
      at_v = BASE_W'(base) + BASE_W'(lo_ff);
      end_v = BASE_W'(base) + BASE_W'(hi_ff);
      rt_ext = ROW_W'(rt);
   end

   assign map_we = (state_ff == ST_CLEAR) || (state_ff == ST_FILL);
   assign map_wd = (state_ff == ST_FILL);
   assign map_wa = addr_ff[ADDR_W-1:0];

   tcr_map u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wa),
      .wr_data (map_wd),
      .rd_addr (idx_ff),
      .rd_data (map_rd)
   );

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      row_len_in = row_len_ff;
      last_row_in = last_row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_val_in = rsp_val_ff;
      val_in = val_ff;
      clr_resp_in = clr_resp_ff;
      tm_inc_in = tm_inc_ff;
      tb_inc_in = tb_inc_ff;
      mb_inc_in = mb_inc_ff;
      linc_in = linc_ff;
      rinc_in = rinc_ff;
      lpos_in = lpos_ff;
      rpos_in = rpos_ff;
      prod_in = prod_ff;
      row_in = row_ff;
      cnt_in = cnt_ff;
      skip_in = skip_ff;
      half_in = half_ff;
      mb_right_in = mb_right_ff;
      div_sel_in = div_sel_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      addr_in = addr_ff;
      end_in = end_ff;

      if (csr_we) begin
         if (csr_index == CSR_ROW_LENGTH) row_len_in = csr_wdata;
         else if (csr_index == CSR_LAST_ROW) last_row_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in = 1'b0;
               addr_in = '0;
               div_sel_in = 2'd0;
               unique case (req_cmd)
                  CMD_CLEAR: begin
                     clr_resp_in = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  CMD_MARK: state_in = ST_DIV_GO;
                  CMD_READ: state_in = ST_READ;
                  default:  state_in = ST_RESP;
               endcase
            end
         end
         ST_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == PLACES_B - 1'b1) begin
               state_in = clr_resp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_READ:  state_in = ST_RWAIT;
         ST_RWAIT: begin
            val_in = map_rd;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in = val_ff;
               state_in = ST_IDLE;
            end
         end
         ST_DIV_GO: state_in = ST_DIV_WT;
         ST_DIV_WT: begin
            if (div_done) begin
               unique case (div_sel_ff)
                  2'd0:    tm_inc_in = div_quot;
                  2'd1:    tb_inc_in = div_quot;
                  default: mb_inc_in = div_quot;
               endcase
               div_sel_in = div_sel_ff + 1'b1;
               state_in = (div_sel_ff == 2'd2) ? ST_PREP : ST_DIV_GO;
            end
         end
         ST_PREP: begin
            // rows above the map are stepped over with one multiply per edge
            row_in = rt_ext[ROW_W-1] ? '0 : rt_ext;
            skip_in = rt_ext[ROW_W-1] ? SKIP_W'(-rt_ext) : '0;
            cnt_in = CNT_W'(rm) - CNT_W'(rt)
                     - (rt_ext[ROW_W-1] ? CNT_W'(-rt_ext) : '0);
            lpos_in = col_pos(ct);
            rpos_in = col_pos(ct);
            if (tm_inc_ff > tb_inc_ff) begin
               linc_in = tb_inc_ff;
               rinc_in = tm_inc_ff;
            end else begin
               linc_in = tm_inc_ff;
               rinc_in = tb_inc_ff;
            end
            state_in = ST_MULL;
         end
         ST_MULL: begin
            prod_in = mul_p[POS_W-1:0];
            state_in = ST_MULR;
         end
         ST_MULR: begin
            lpos_in = lpos_ff + prod_ff;
            prod_in = mul_p[POS_W-1:0];
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            rpos_in = rpos_ff + prod_ff;
            if (cnt_ff > 0) begin
               half_in = 1'b0;
               state_in = ST_SPAN;
            end else begin
               // upper half is empty or lies wholly above row 0
               skip_in = SKIP_W'(-cnt_ff);
               cnt_in = CNT_W'(rbo) - CNT_W'(rm) + cnt_ff;
               state_in = ST_HALF2;
            end
         end
         ST_HALF2: begin
            if (cnt_ff <= 0) begin
               state_in = ST_RESP;
            end else begin
               mb_right_in = (tb_inc_ff > mb_inc_ff);
               if (tb_inc_ff > mb_inc_ff) rinc_in = mb_inc_ff;
               else linc_in = mb_inc_ff;
               prod_in = mul_p[POS_W-1:0];
               state_in = ST_HALF2B;
            end
         end
         ST_HALF2B: begin
            if (mb_right_ff) rpos_in = col_pos(cm) + prod_ff;
            else lpos_in = col_pos(cm) + prod_ff;
            half_in = 1'b1;
            state_in = ST_SPAN;
         end
         ST_SPAN: begin
            if (row_ff > $signed({{(ROW_W-CFG_W){1'b0}}, last_row_ff})) begin
               // every later row is past the map too
               state_in = ST_RESP;
            end else if (hi_t <= lo_t || hi_c <= lo_c) begin
               state_in = ST_NEXT;
            end else begin
               lo_in = lo_c[CFG_W-1:0];
               hi_in = hi_c[CFG_W-1:0];
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            addr_in = at_v;
            end_in = end_v;
            state_in = (end_v > PLACES_B) ? ST_NEXT : ST_FILL;
         end
         ST_FILL: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff + 1'b1 == end_ff) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            lpos_in = lpos_ff + POS_W'(linc_ff);
            rpos_in = rpos_ff + POS_W'(rinc_ff);
            row_in = row_ff + 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               if (!half_ff) begin
                  cnt_in = CNT_W'(rbo) - CNT_W'(rm);
                  skip_in = '0;
                  state_in = ST_HALF2;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               state_in = ST_SPAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff <= '0;
         clr_resp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_len_ff <= '0;
         last_row_ff <= '0;
         div_sel_ff <= '0;
         half_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         clr_resp_ff <= clr_resp_in;
         rsp_valid_ff <= rsp_valid_in;
         row_len_ff <= row_len_in;
         last_row_ff <= last_row_in;
         div_sel_ff <= div_sel_in;
         half_ff <= half_in;
      end
      if (req_valid && req_ready) begin
         cmd_ff <= req_cmd;
         ra_ff <= req_row_a;
         rb_ff <= req_row_b;
         rc_ff <= req_row_c;
         ca_ff <= req_col_a;
         cb_ff <= req_col_b;
         cc_ff <= req_col_c;
         idx_ff <= req_read_index;
      end
      rsp_val_ff <= rsp_val_in;
      val_ff <= val_in;
      tm_inc_ff <= tm_inc_in;
      tb_inc_ff <= tb_inc_in;
      mb_inc_ff <= mb_inc_in;
      linc_ff <= linc_in;
      rinc_ff <= rinc_in;
      lpos_ff <= lpos_in;
      rpos_ff <= rpos_in;
      prod_ff <= prod_in;
      row_ff <= row_in;
      cnt_ff <= cnt_in;
      skip_ff <= skip_in;
      mb_right_ff <= mb_right_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      end_ff <= end_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_place_value = rsp_val_ff;

   // span writes never leave the map
   a_fill_in_map: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FILL |-> addr_ff < PLACES_B && end_ff <= PLACES_B)
      else $error("fill address past map");

   // only reads return a set bit
   a_value_from_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && val_ff) |-> cmd_ff == CMD_READ)
      else $error("set value for non-read command");

   // divider finishes only while the sequencer waits on it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WT)
      else $error("divider result with no waiter");

   // an accepted request always leaves idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff != ST_IDLE)
      else $error("request accepted but sequencer idle");

endmodule

/* tb/triangle_coverage_rasterizer_tb.sv */
// ----------------------------------------------------------------------------
// triangle_coverage_rasterizer_tb: self-checking bench for the rasterizer
// Drives clear, mark, read and unused commands through the valid/ready
// request channel. It predicts each response with its own fixed-point
// scanline fill of a shadow coverage map and checks the responses in order.
// It steps through several row_length / last_row settings, the extremes
// among them, with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_coverage_rasterizer_tb import tcr_pkg::*; ();

   localparam logic [1:0] CMD_UNUSED = 2'd3;   // no-op command, responds 0
   localparam longint ONE_FX = longint'(1) << FRAC_BITS;
   localparam int LIMIT_CYCLES = 20_000_000;
   localparam int DRAIN_CYCLES = 200;

   // Expected place_value bits, oldest first.
   class coverage_scoreboard;
      bit pending[$];
      int mismatches;
      int unexpected;

      function void note(bit value);
         pending.push_back(value);
      endfunction

      function void check(bit actual);
         bit want;
         if (pending.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("response with nothing pending: place_value=%0b", actual);
            return;
         end
         want = pending.pop_front();
         if (want != actual) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
               $display("place_value mismatch: expected %0b, got %0b", want, actual);
         end
      endfunction

      function bit drained();
         return pending.size() == 0;
      endfunction
   endclass

   typedef struct {
      logic [1:0]                cmd;
      logic signed [COORD_W-1:0] row [3];
      logic signed [COORD_W-1:0] col [3];
      logic [ADDR_W-1:0]         index;
   } request_t;

   typedef struct {
      longint pos;
      longint inc;
   } edge_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_cmd = CMD_CLEAR;
   logic signed [COORD_W-1:0] req_row_a = '0, req_row_b = '0, req_row_c = '0;
   logic signed [COORD_W-1:0] req_col_a = '0, req_col_b = '0, req_col_c = '0;
   logic [ADDR_W-1:0]         req_read_index = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_place_value;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_ROW_LENGTH;
   logic [CFG_W-1:0]          csr_wdata = '0;

   // Shadow state of the block
   bit        shadow_map [PLACES];
   longint    shadow_row_length;
   longint    shadow_last_row;

   coverage_scoreboard sb = new();
   bit  steady;         // when set, neither side inserts gaps
   int  cycle_count;

   triangle_coverage_rasterizer DUT (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction: fixed-point scanline fill
   // ---------------------------------------------------------------------
   function automatic edge_t edge_from(longint a, longint b, longint rows);
      edge_t e;
      longint d;
      d = rows < 1 ? 1 : rows;
      e.pos = a * ONE_FX;
      e.inc = ((b - a) * ONE_FX) / d;   // truncates toward zero
      return e;
   endfunction

   function automatic void span_fill(longint row, longint lpos, longint rpos);
      longint lo, hi, at;
      lo = lpos / ONE_FX;
      hi = rpos / ONE_FX;
      if (row < 0 || row > shadow_last_row || hi <= lo) return;
      if (lo < 0) lo = 0;
      if (hi > shadow_row_length) hi = shadow_row_length;
      if (hi <= lo) return;
      at = row * shadow_row_length + lo;
      // spans running past the map capacity are dropped whole
      if (at < 0 || at + (hi - lo) > PLACES) return;
      for (longint p = at; p < at + (hi - lo); p++) shadow_map[p] = 1'b1;
   endfunction

   function automatic void rows_walk(longint row, longint count,
                                     inout edge_t l, inout edge_t r);
      for (longint k = 0; k < count; k++) begin
         span_fill(row + k, l.pos, r.pos);
         l.pos += l.inc;
         r.pos += r.inc;
      end
   endfunction

   function automatic void triangle_mark(request_t q);
      longint dn [3], ac [3];
      int t, m, b;
      longint row, skip, cnt;
      edge_t tm, tb, mb, l, r;
      for (int i = 0; i < 3; i++) begin
         dn[i] = q.row[i];
         ac[i] = q.col[i];
      end
      // sort corners top / middle / bottom, ties resolved as in the block
      if (dn[1] > dn[0]) begin
         if (dn[2] > dn[1])      begin t = 0; m = 1; b = 2; end
         else if (dn[2] > dn[0]) begin t = 0; m = 2; b = 1; end
         else                    begin t = 2; m = 0; b = 1; end
      end else if (dn[2] > dn[0]) begin t = 1; m = 0; b = 2; end
      else if (dn[2] > dn[1])     begin t = 1; m = 2; b = 0; end
      else                        begin t = 2; m = 1; b = 0; end

      tm = edge_from(ac[t], ac[m], dn[m] - dn[t]);
      tb = edge_from(ac[t], ac[b], dn[b] - dn[t]);
      mb = edge_from(ac[m], ac[b], dn[b] - dn[m]);

      // rows above the map are stepped over, not walked
      row  = dn[t] < 0 ? 0 : dn[t];
      skip = row - dn[t];
      cnt  = dn[m] - dn[t] - skip;

      if (tm.inc > tb.inc) begin l = tb; r = tm; end
      else begin l = tm; r = tb; end
      l.pos += l.inc * skip;
      r.pos += r.inc * skip;

      if (cnt > 0) begin
         rows_walk(row, cnt, l, r);
         row += cnt;
         skip = 0;
         cnt = dn[b] - dn[m];
      end else begin
         skip = -cnt;
         cnt = dn[b] - dn[m] + cnt;
      end

      // lower half: the middle-to-bottom edge replaces one side
      if (cnt > 0) begin
         if (tb.inc > mb.inc) begin
            r = mb;
            r.pos = ac[m] * ONE_FX + r.inc * skip;
         end else begin
            l = mb;
            l.pos = ac[m] * ONE_FX + l.inc * skip;
         end
         rows_walk(row, cnt, l, r);
      end
   endfunction

   function automatic bit place_predict(request_t q);
      case (q.cmd)
         CMD_CLEAR: begin
            foreach (shadow_map[i]) shadow_map[i] = 1'b0;
            return 1'b0;
         end
         CMD_MARK: begin
            triangle_mark(q);
            return 1'b0;
         end
         CMD_READ: return (q.index < PLACES) ? shadow_map[q.index] : 1'b0;
         default: return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Drivers (all called right after a rising edge)
   // ---------------------------------------------------------------------
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_ROW_LENGTH) shadow_row_length = value;
      else shadow_last_row = value;
      @(posedge clock);
   endtask

   // Holds valid until the transfer, then notes the expected response.
   // The reads of req_ready see pre-edge values, so the test is race free.
   task automatic request_send(request_t q);
      req_valid      <= 1'b1;
      req_cmd        <= q.cmd;
      req_row_a      <= q.row[0];
      req_row_b      <= q.row[1];
      req_row_c      <= q.row[2];
      req_col_a      <= q.col[0];
      req_col_b      <= q.col[1];
      req_col_c      <= q.col[2];
      req_read_index <= q.index;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note(place_predict(q));
      // occasional gap after the transfer
      if (!steady && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      @(posedge clock);
      while (!sb.drained()) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Response side: check on transfer, then pick next ready.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check(rsp_place_value);
         rsp_ready <= steady || ($urandom_range(99) >= 13);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic signed [COORD_W-1:0] any_coord();
      return COORD_W'($urandom_range(0, 8191));
   endfunction

   function automatic logic signed [COORD_W-1:0] coord_near(longint hi);
      return COORD_W'(longint'($urandom_range(0, hi + 16)) - 8);
   endfunction

   function automatic request_t random_request();
      request_t q;
      int pick;
      int used;
      pick = $urandom_range(99);
      q.cmd = pick < 45 ? CMD_MARK : pick < 93 ? CMD_READ :
              pick < 95 ? CMD_CLEAR : CMD_UNUSED;
      for (int i = 0; i < 3; i++) begin
         if ($urandom_range(99) < 10) begin
            q.row[i] = any_coord();
            q.col[i] = any_coord();
         end else begin
            q.row[i] = coord_near(shadow_last_row);
            q.col[i] = coord_near(shadow_row_length);
         end
      end
      // flat halves now and then
      if ($urandom_range(99) < 15) q.row[$urandom_range(1, 2)] = q.row[0];
      used = int'(shadow_row_length * (shadow_last_row + 1));
      if (used > PLACES) used = PLACES;
      if (used > 0 && $urandom_range(99) < 80) q.index = ADDR_W'($urandom_range(0, used - 1));
      else q.index = ADDR_W'($urandom_range(0, PLACES - 1));
      return q;
   endfunction

   function automatic request_t tri_req(int r0, int r1, int r2, int c0, int c1, int c2);
      request_t q;
      q.cmd = CMD_MARK;
      q.row[0] = COORD_W'(r0); q.row[1] = COORD_W'(r1); q.row[2] = COORD_W'(r2);
      q.col[0] = COORD_W'(c0); q.col[1] = COORD_W'(c1); q.col[2] = COORD_W'(c2);
      q.index = '0;
      return q;
   endfunction

   function automatic request_t plain_req(logic [1:0] cmd, int idx);
      request_t q;
      q = tri_req(0, 0, 0, 0, 0, 0);
      q.cmd = cmd;
      q.index = ADDR_W'(idx);
      return q;
   endfunction

   // row_length, last_row, random items per phase
   int phase_cfg [8][3] = '{'{16, 16, 150}, '{255, 255, 20}, '{0, 0, 40},
                            '{40, 100, 150}, '{128, 127, 30}, '{7, 255, 120},
                            '{255, 0, 60}, '{1, 200, 80}};

   initial begin
      request_t directed [$];
      foreach (shadow_map[i]) shadow_map[i] = 1'b0;
      shadow_row_length = 0;
      shadow_last_row   = 0;
      steady = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed set on a 16 x 17 map
      csr_write(CSR_ROW_LENGTH, 8'd16);
      csr_write(CSR_LAST_ROW, 8'd16);
      directed.push_back(plain_req(CMD_CLEAR, 0));
      directed.push_back(tri_req(0, 8, 16, 0, 15, 4));             // general
      directed.push_back(plain_req(CMD_READ, 4 * 16 + 3));
      directed.push_back(plain_req(CMD_READ, 0));
      directed.push_back(tri_req(2, 2, 10, 1, 12, 6));             // flat top
      directed.push_back(tri_req(12, 3, 12, 0, 7, 15));            // flat bottom
      directed.push_back(tri_req(5, 5, 5, 0, 15, 8));              // all on one row
      directed.push_back(tri_req(-4096, -4096, 4095, -4096, 4095, 4095)); // extremes
      directed.push_back(tri_req(4095, 4095, 4095, 4095, 4095, 4095));
      directed.push_back(tri_req(-4096, -4096, -4096, -4096, -4096, -4096));
      directed.push_back(tri_req(-6, 20, 3, -30, 40, 8));          // partly off map
      directed.push_back(tri_req(9, 1, 14, 14, 2, 0));             // reversed order
      directed.push_back(plain_req(CMD_READ, 16383));              // past used area
      directed.push_back(plain_req(CMD_READ, 9 * 16 + 5));
      directed.push_back(plain_req(CMD_UNUSED, 21));
      directed.push_back(plain_req(CMD_READ, 10 * 16 + 8));
      directed.push_back(plain_req(CMD_CLEAR, 0));
      directed.push_back(plain_req(CMD_READ, 10 * 16 + 8));
      foreach (directed[i]) request_send(directed[i]);
      drain_wait();

      foreach (phase_cfg[p]) begin
         drain_wait();
         csr_write(CSR_ROW_LENGTH, CFG_W'(phase_cfg[p][0]));
         csr_write(CSR_LAST_ROW, CFG_W'(phase_cfg[p][1]));
         for (int n = 0; n < phase_cfg[p][2]; n++) begin
            // the first stretch of the first phase runs without gaps
            steady = (p == 0 && n < 60);
            if (p == 3 && n == 20) drain_wait();   // sender holds off until idle
            request_send(random_request());
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (!sb.drained()) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.unexpected == 0 && sb.drained())
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
